// File: rtl/gamepad_text_report_scanner_unit_assert.svh
// ----------------------------------------------------------------------------
// gamepad_text_report_scanner_unit_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_TEXT_REPORT_SCANNER_UNIT_ASSERT_SVH
`define GAMEPAD_TEXT_REPORT_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define GTRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gtrs assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GTRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gtrs assertion failed");

`endif

// File: rtl/gtrs_pkg.sv
// ----------------------------------------------------------------------------
// gtrs_pkg
// types, character codes and bit positions for the gamepad report scanner
// ----------------------------------------------------------------------------
package gtrs_pkg;

	// window geometry
	localparam int WIN_DEPTH = 13;
	localparam int LOOK_DEPTH = WIN_DEPTH + 1;
	localparam int FILL_W = 4;
	localparam int NUM_FLAGS = 18;
	localparam int NUM_AXES = 6;
	localparam int VAL_W = 11;

	// flag bit positions
	localparam int B_LH = 0;
	localparam int B_RH = 1;
	localparam int B_L2 = 2;
	localparam int B_R2 = 3;
	localparam int B_TRI = 4;
	localparam int B_CIR = 5;
	localparam int B_CRO = 6;
	localparam int B_SQU = 7;
	localparam int B_UP = 8;
	localparam int B_RIGHT = 9;
	localparam int B_DOWN = 10;
	localparam int B_LEFT = 11;
	localparam int B_L1 = 12;
	localparam int B_L3 = 13;
	localparam int B_R1 = 14;
	localparam int B_R3 = 15;
	localparam int B_SHARE = 16;
	localparam int B_OPTIONS = 17;

	// analog value slots
	localparam int AX_LX = 0;
	localparam int AX_LY = 1;
	localparam int AX_RX = 2;
	localparam int AX_RY = 3;
	localparam int AX_LA = 4;
	localparam int AX_RA = 5;

	// ascii codes of the key letters
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_Q = 8'h51;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_X = 8'h58;
	localparam logic [7:0] CH_Y = 8'h59;
	localparam logic [7:0] CH_E_LC = 8'h65;
	localparam logic [7:0] CH_I_LC = 8'h69;

	// decimal weights of the hundreds and tens digits
	localparam logic [VAL_W-1:0] WEIGHT_HUNDREDS = 11'd100;
	localparam logic [VAL_W-1:0] WEIGHT_TENS = 11'd10;

	// character window: byte 0 is the position judged, the rest lookahead
	typedef logic [WIN_DEPTH-1:0][7:0] win_t;
	typedef logic [LOOK_DEPTH-1:0][7:0] look_t;

	// what one judged position contributes
	typedef struct packed {
		logic [NUM_FLAGS-1:0] flags;
		logic [NUM_AXES-1:0] axis_we;
		logic [VAL_W-1:0] value;
	} judge_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/gamepad_text_report_scanner_unit.sv
// ----------------------------------------------------------------------------
// gamepad_text_report_scanner_unit
// scans an ascii gamepad report one character at a time and emits button
// held/rise/fall masks and analog values at the end of each report
// ----------------------------------------------------------------------------
//  channel   dir   transaction                     tdata / tuser / tlast
//  s_*       in    one report character            tdata[7:0] character, tlast last
//  m_*       out   one report summary              tdata[119:0] masks and values
//
//  one character per cycle while the report runs; the 13-byte window plus the
//  incoming character feeds the single judge unit once per character once full.
//  the last character starts a flush that judges each window entry still
//  pending (1 to 13) through the same judge unit, then loads the result.
//  s_tready is low during flush and while a finished result waits for a free
//  output register; the output register lets the next report start meanwhile.
//  reset clears the window, the fill count, the masks and the analog values.
// ----------------------------------------------------------------------------
module gamepad_text_report_scanner_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] character
	input  logic         s_tlast,   // last
	output logic         m_tvalid,
	input  logic         m_tready,
	// [17:0] held_mask, [35:18] rise_mask, [53:36] fall_mask, [64:54] left_x,
	// [75:65] left_y, [86:76] right_x, [97:87] right_y, [108:98] left_trigger,
	// [119:109] right_trigger
	output logic [119:0] m_tdata
);

	gtrs_pkg::state_t state_q;
	gtrs_pkg::state_t state_d;

	gtrs_pkg::win_t win_q;
	logic [gtrs_pkg::FILL_W-1:0] fill_q;
	logic [gtrs_pkg::NUM_FLAGS-1:0] flags_bld_q;
	logic [gtrs_pkg::NUM_FLAGS-1:0] flags_prev_q;
	logic [gtrs_pkg::NUM_AXES-1:0][gtrs_pkg::VAL_W-1:0] axis_q;
	logic m_tvalid_q;
	logic [119:0] m_tdata_q;

	logic s_acc;
	logic win_full;
	logic judge_en;
	logic flush_step;
	logic load_out;
	logic [7:0] tail_char;
	gtrs_pkg::look_t look;
	gtrs_pkg::judge_t jres;
	logic [gtrs_pkg::NUM_FLAGS-1:0] held;

	assign win_full = (fill_q == gtrs_pkg::FILL_W'(gtrs_pkg::WIN_DEPTH));
	assign s_acc = s_tvalid && s_tready;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and step controls
	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		flush_step = 1'b0;
		load_out = 1'b0;
		case (state_q)
			gtrs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) state_d = gtrs_pkg::ST_FLUSH;
			end
			gtrs_pkg::ST_FLUSH: begin
				flush_step = 1'b1;
				if (fill_q == gtrs_pkg::FILL_W'(1)) state_d = gtrs_pkg::ST_EMIT;
			end
			gtrs_pkg::ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d = gtrs_pkg::ST_IDLE;
				end
			end
			default: state_d = gtrs_pkg::ST_IDLE;
		endcase
	end

	// lookahead: window plus the incoming character, or nul while flushing
	assign tail_char = flush_step ? gtrs_pkg::CH_NUL : s_tdata;
	assign look = {tail_char, win_q};
	assign judge_en = flush_step || (s_acc && win_full);

	gtrs_judge u_judge (
		.look (look),
		.res  (jres)
	);

	// character window and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			fill_q <= '0;
		end else if (flush_step) begin
			win_q <= {gtrs_pkg::CH_NUL, win_q[gtrs_pkg::WIN_DEPTH-1:1]};
			fill_q <= fill_q - gtrs_pkg::FILL_W'(1);
		end else if (s_acc) begin
			if (win_full) begin
				win_q <= {s_tdata, win_q[gtrs_pkg::WIN_DEPTH-1:1]};
			end else begin
				win_q[fill_q] <= s_tdata;
				fill_q <= fill_q + gtrs_pkg::FILL_W'(1);
			end
		end
	end

	// flags of the current and previous report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_bld_q <= '0;
			flags_prev_q <= '0;
		end else if (load_out) begin
			flags_prev_q <= flags_bld_q;
			flags_bld_q <= '0;
		end else if (judge_en) begin
			flags_bld_q <= flags_bld_q | jres.flags;
		end
	end

	// analog values, kept across reports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
		end else if (judge_en) begin
			for (int i = 0; i < gtrs_pkg::NUM_AXES; i++) begin
				if (jres.axis_we[i]) axis_q[i] <= jres.value;
			end
		end
	end

	assign held = flags_bld_q;

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {axis_q[gtrs_pkg::AX_RA], axis_q[gtrs_pkg::AX_LA],
				axis_q[gtrs_pkg::AX_RY], axis_q[gtrs_pkg::AX_RX],
				axis_q[gtrs_pkg::AX_LY], axis_q[gtrs_pkg::AX_LX],
				flags_prev_q & ~held, held & ~flags_prev_q, held};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// File: rtl/gtrs_judge.sv
// ----------------------------------------------------------------------------
// gtrs_judge
// key decoder and three-digit evaluator, shared by every window position
// ----------------------------------------------------------------------------
module gtrs_judge (
	input  gtrs_pkg::look_t  look,
	output gtrs_pkg::judge_t res
);

	logic [gtrs_pkg::NUM_FLAGS-1:0] flags;
	logic [gtrs_pkg::NUM_AXES-1:0] axis_we;
	logic [3:0] dig_h;
	logic [3:0] dig_t;
	logic [3:0] dig_o;

	// key decode and digit selection
	always_comb begin
		flags = '0;
		axis_we = '0;
		dig_h = '0;
		dig_t = '0;
		dig_o = '0;
		case (look[0])
			gtrs_pkg::CH_L: begin
				case (look[1])
					gtrs_pkg::CH_1: flags[gtrs_pkg::B_L1] = 1'b1;
					gtrs_pkg::CH_2: begin
						flags[gtrs_pkg::B_L2] = 1'b1;
						axis_we[gtrs_pkg::AX_LA] = 1'b1;
						dig_h = look[4][3:0];
						dig_t = look[5][3:0];
						dig_o = look[6][3:0];
					end
					gtrs_pkg::CH_3: flags[gtrs_pkg::B_L3] = 1'b1;
					gtrs_pkg::CH_E_LC: begin
						dig_h = look[10][3:0];
						dig_t = look[11][3:0];
						dig_o = look[12][3:0];
						if (look[7] == gtrs_pkg::CH_X) begin
							axis_we[gtrs_pkg::AX_LX] = 1'b1;
							flags[gtrs_pkg::B_LH] = 1'b1;
						end else if (look[7] == gtrs_pkg::CH_Y) begin
							axis_we[gtrs_pkg::AX_LY] = 1'b1;
							flags[gtrs_pkg::B_LH] = 1'b1;
						end
					end
					gtrs_pkg::CH_E: begin
						if (look[2] == gtrs_pkg::CH_F) flags[gtrs_pkg::B_LEFT] = 1'b1;
					end
					default: ;
				endcase
			end
			gtrs_pkg::CH_R: begin
				case (look[1])
					gtrs_pkg::CH_1: flags[gtrs_pkg::B_R1] = 1'b1;
					gtrs_pkg::CH_2: begin
						flags[gtrs_pkg::B_R2] = 1'b1;
						axis_we[gtrs_pkg::AX_RA] = 1'b1;
						dig_h = look[4][3:0];
						dig_t = look[5][3:0];
						dig_o = look[6][3:0];
					end
					gtrs_pkg::CH_3: flags[gtrs_pkg::B_R3] = 1'b1;
					gtrs_pkg::CH_I_LC: begin
						dig_h = look[11][3:0];
						dig_t = look[12][3:0];
						dig_o = look[13][3:0];
						if (look[8] == gtrs_pkg::CH_X) begin
							axis_we[gtrs_pkg::AX_RX] = 1'b1;
							flags[gtrs_pkg::B_RH] = 1'b1;
						end else if (look[8] == gtrs_pkg::CH_Y) begin
							axis_we[gtrs_pkg::AX_RY] = 1'b1;
							flags[gtrs_pkg::B_RH] = 1'b1;
						end
					end
					gtrs_pkg::CH_I: begin
						if (look[2] == gtrs_pkg::CH_G) flags[gtrs_pkg::B_RIGHT] = 1'b1;
					end
					default: ;
				endcase
			end
			gtrs_pkg::CH_U: begin
				if (look[1] == gtrs_pkg::CH_P) flags[gtrs_pkg::B_UP] = 1'b1;
			end
			gtrs_pkg::CH_D: begin
				if (look[1] == gtrs_pkg::CH_O) flags[gtrs_pkg::B_DOWN] = 1'b1;
			end
			gtrs_pkg::CH_T: begin
				if (look[1] == gtrs_pkg::CH_R) flags[gtrs_pkg::B_TRI] = 1'b1;
			end
			gtrs_pkg::CH_C: begin
				if (look[1] == gtrs_pkg::CH_R) flags[gtrs_pkg::B_CRO] = 1'b1;
				else if (look[1] == gtrs_pkg::CH_I) flags[gtrs_pkg::B_CIR] = 1'b1;
			end
			gtrs_pkg::CH_S: begin
				if (look[1] == gtrs_pkg::CH_Q) flags[gtrs_pkg::B_SQU] = 1'b1;
				else if (look[1] == gtrs_pkg::CH_H) flags[gtrs_pkg::B_SHARE] = 1'b1;
			end
			gtrs_pkg::CH_O: begin
				if (look[1] == gtrs_pkg::CH_P) flags[gtrs_pkg::B_OPTIONS] = 1'b1;
			end
			default: ;
		endcase
	end

	// low nibbles weighted 100, 10, 1
	assign res.flags = flags;
	assign res.axis_we = axis_we;
	assign res.value = gtrs_pkg::VAL_W'(dig_h) * gtrs_pkg::WEIGHT_HUNDREDS
		+ gtrs_pkg::VAL_W'(dig_t) * gtrs_pkg::WEIGHT_TENS
		+ gtrs_pkg::VAL_W'(dig_o);

endmodule

// File: rtl/gtrs_checker.sv
// ----------------------------------------------------------------------------
// gtrs_checker
// port-level checks on the gamepad report scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "gamepad_text_report_scanner_unit_assert.svh"

module gtrs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata
);

	logic [17:0] held;
	logic [17:0] rise;
	logic [17:0] fall;

	assign held = m_tdata[17:0];
	assign rise = m_tdata[35:18];
	assign fall = m_tdata[53:36];

	// a stalled result stays offered and unchanged
	`GTRS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`GTRS_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// the end of a report always starts a flush, so input stalls next cycle
	`GTRS_ASSERT_NEXT(a_flush_stall, clk, arst_n, s_tvalid && s_tready && s_tlast, !s_tready)

	// rising flags are held now, falling flags are not
	`GTRS_ASSERT_SAME(a_rise_held, clk, arst_n, m_tvalid, (rise & ~held) == 18'd0)
	`GTRS_ASSERT_SAME(a_fall_clear, clk, arst_n, m_tvalid, (fall & held) == 18'd0)

endmodule

bind gamepad_text_report_scanner_unit gtrs_checker u_gtrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
